@@ sv/kcc_pkg.sv @@
// ----------------------------------------------------------------------------
// kcc_pkg
// Shared sizes and the combo table entry layout for the chord matcher.
// ----------------------------------------------------------------------------
package kcc_pkg;

  localparam int BUTTON_COUNT   = 64;
  localparam int COMBO_SLOTS    = 16;
  localparam int PENDING_DEPTH  = 8;
  localparam int MAX_COMBO_KEYS = 8;

  localparam int MASK_W   = 64;
  localparam int MIDX_W   = $clog2(MASK_W);
  localparam int KEY_LIMIT = (BUTTON_COUNT < MASK_W) ? BUTTON_COUNT : MASK_W;
  localparam int LIST_W   = 64;
  localparam int BYTE_W   = 8;
  localparam int LIST_BYTES = LIST_W / BYTE_W;
  localparam int WAIT_W   = 16;
  localparam int TIME_W   = 32;
  localparam int KEY_W    = 6;
  localparam int KIND_W   = 3;
  localparam int EV_W     = 2;
  localparam int COMBO_W  = 4;
  localparam int SLOT_W   = (COMBO_SLOTS > 1) ? $clog2(COMBO_SLOTS) : 1;
  localparam int PEND_W   = $clog2(PENDING_DEPTH);
  localparam int CNT_W    = $clog2(PENDING_DEPTH + 1);

  localparam logic [BYTE_W-1:0] LIST_END = 8'hff;

  typedef struct packed {
    logic              usable;
    logic              ordered;
    logic [WAIT_W-1:0] wait_ms;
    logic [MASK_W-1:0] mask;
    logic [LIST_W-1:0] list;
  } combo_ent_t;

  localparam int ENT_W = $bits(combo_ent_t);

endpackage

@@ sv/key_combo_chord_matcher.sv @@
// ----------------------------------------------------------------------------
// key_combo_chord_matcher
// Turns button press and release events into button and combo events.
// ----------------------------------------------------------------------------
// An event is taken when start is high and busy is low. Its results are
// strobed out on out_valid, at most one per cycle, with out_last on the final
// one. busy drops in the same cycle that carries that final beat, so a new
// event can be taken there. A define writes its slot at once; a reset-all
// walks every slot in turn, releasing pressed combos, then clears the table.
// Matching walks the combo table through the single read port of the table
// RAM and then acts on the result, so a press or a flush takes at most one walk
// for each queued press it resolves, up to PENDING_DEPTH + 1 walks for one press; a release that ends a
// combo adds one more walk. Results are strobed once and cannot be held off.
module key_combo_chord_matcher
  import kcc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [KEY_W-1:0]   in_button,
  input  logic [TIME_W-1:0]  in_now_ms,
  input  logic [COMBO_W-1:0] in_slot,
  input  logic [LIST_W-1:0]  in_combo_keys,
  input  logic               in_ordered,
  input  logic [WAIT_W-1:0]  in_timeout_ms,
  output logic               out_valid,
  output logic [EV_W-1:0]    out_event_res,
  output logic [KEY_W-1:0]   out_key,
  output logic [COMBO_W-1:0] out_combo,
  output logic [TIME_W-1:0]  out_stamp_ms,
  output logic               out_last
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_ACT, S_PUSH, S_REL_CHK, S_RSCAN, S_RSTALL, S_DONE
  } state_t;

  typedef enum logic [1:0] {M_FULLQ, M_PRESS, M_FLUSH} mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PRESS, KIND_RELEASE, KIND_TICK, KIND_DEFINE, KIND_RESET_ALL
  } kind_t;

  typedef enum logic [EV_W-1:0] {
    EV_BTN_PRESS, EV_BTN_RELEASE, EV_COMBO_PRESS, EV_COMBO_RELEASE
  } ev_t;

  localparam logic [SLOT_W:0] SCAN_END = (SLOT_W+1)'(COMBO_SLOTS);

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic [KEY_W-1:0]   btn_r, btn_nxt;
  logic [TIME_W-1:0]  now_r, now_nxt;
  logic [KEY_W-1:0]   key_r [PENDING_DEPTH];
  logic [KEY_W-1:0]   key_nxt [PENDING_DEPTH];
  logic [TIME_W-1:0]  time_r [PENDING_DEPTH];
  logic [TIME_W-1:0]  time_nxt [PENDING_DEPTH];
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [MASK_W-1:0]  active_r, active_nxt;
  logic               timer_r, timer_nxt;
  logic [TIME_W-1:0]  deadline_r, deadline_nxt;
  logic [COMBO_SLOTS-1:0] valid_r, valid_nxt;
  logic [COMBO_SLOTS-1:0] pressed_r, pressed_nxt;
  logic [COMBO_SLOTS-1:0] released_r, released_nxt;
  logic [SLOT_W:0]    rd_r, rd_nxt;
  logic [CNT_W-1:0]   flush_c_r, flush_c_nxt;
  logic [PENDING_DEPTH-1:0] fhit_r, fhit_nxt;
  logic [SLOT_W-1:0]  fidx_r [PENDING_DEPTH];
  logic [SLOT_W-1:0]  fidx_nxt [PENDING_DEPTH];
  logic               phit_r, phit_nxt;
  logic [WAIT_W-1:0]  pwait_r, pwait_nxt;
  logic               hold_v_r, hold_v_nxt;
  logic [EV_W-1:0]    hold_ev_r, hold_ev_nxt;
  logic [KEY_W-1:0]   hold_key_r, hold_key_nxt;
  logic [SLOT_W-1:0]  hold_combo_r, hold_combo_nxt;
  logic [TIME_W-1:0]  hold_stamp_r, hold_stamp_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_last_r, out_last_nxt;
  logic [EV_W-1:0]    out_ev_r, out_ev_nxt;
  logic [KEY_W-1:0]   out_key_r, out_key_nxt;
  logic [SLOT_W-1:0]  out_combo_r, out_combo_nxt;
  logic [TIME_W-1:0]  out_stamp_r, out_stamp_nxt;

  // table ram
  logic               ram_we;
  logic [SLOT_W-1:0]  ram_waddr;
  combo_ent_t         def_ent;
  logic [ENT_W-1:0]   ram_rdata;
  combo_ent_t         ent;

  // match lanes, lane j covers the first j+1 queued presses
  logic [MASK_W-1:0]  st [PENDING_DEPTH];
  logic [PENDING_DEPTH-1:0] eq, ordok, lane_ok, fm;
  logic [SLOT_W:0]    rd_m1;
  logic [SLOT_W-1:0]  ev_idx;
  logic               slot_ok;

  // trigger selection
  logic [CNT_W-1:0]   trig_max;
  logic               tr_found;
  logic [CNT_W-1:0]   tr_len, tr_t;
  logic [PEND_W-1:0]  tr_sel;
  logic [CNT_W-1:0]   cnt_m1;
  logic [PEND_W-1:0]  cnt_sel;

  logic               any_valid, btn_ok, slot_in_ok, due, rel_found;
  logic [CNT_W-1:0]   rel_c;
  logic [TIME_W-1:0]  due_diff;

  // emit request
  logic               em_v;
  logic [EV_W-1:0]    em_ev;
  logic [KEY_W-1:0]   em_key;
  logic [SLOT_W-1:0]  em_combo;
  logic [TIME_W-1:0]  em_stamp;
  logic               do_trig, start_scan;
  logic [CNT_W-1:0]   pop_amt;

  kcc_ram #(.WIDTH(ENT_W), .DEPTH(COMBO_SLOTS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (def_ent),
    .raddr (rd_r[SLOT_W-1:0]),
    .rdata (ram_rdata)
  );

  assign ent       = combo_ent_t'(ram_rdata);
  assign ram_waddr = SLOT_W'(in_slot);
  assign any_valid = |valid_r;
  assign btn_ok    = int'(in_button) < KEY_LIMIT;
  assign slot_in_ok = int'(in_slot) < COMBO_SLOTS;
  assign due_diff  = in_now_ms - deadline_r;
  assign due       = !due_diff[TIME_W-1];
  assign rd_m1     = rd_r - 1'b1;
  assign ev_idx    = rd_m1[SLOT_W-1:0];
  assign cnt_m1    = cnt_r - 1'b1;
  assign cnt_sel   = cnt_m1[PEND_W-1:0];
  assign busy      = (state_r != S_IDLE);

  // list cleanup at define: bytes after the terminator read as terminator
  always_comb begin
    logic term;
    logic [BYTE_W-1:0] b;
    term = 1'b0;
    def_ent.usable  = 1'b1;
    def_ent.ordered = in_ordered;
    def_ent.wait_ms = in_timeout_ms;
    def_ent.mask    = '0;
    def_ent.list    = '1;
    for (int i = 0; i < LIST_BYTES; i++) begin
      b = in_combo_keys[i*BYTE_W +: BYTE_W];
      if (i >= MAX_COMBO_KEYS || b == LIST_END) begin
        term = 1'b1;
      end
      if (!term) begin
        def_ent.list[i*BYTE_W +: BYTE_W] = b;
        if (b < BYTE_W'(MASK_W)) begin
          def_ent.mask[b[MIDX_W-1:0]] = 1'b1;
        end
        if (int'(b) >= KEY_LIMIT) begin
          def_ent.usable = 1'b0;
        end
      end
    end
  end

  // prefix masks and per-lane match of the slot coming out of the ram
  always_comb begin
    logic [MASK_W-1:0] acc;
    acc = '0;
    for (int j = 0; j < PENDING_DEPTH; j++) begin
      acc   = acc | (MASK_W'(1) << key_r[j]);
      st[j] = acc;
    end
    for (int i = 0; i < PENDING_DEPTH; i++) begin
      if (i < MAX_COMBO_KEYS) begin
        eq[i] = ent.list[i*BYTE_W +: BYTE_W] == BYTE_W'(key_r[i]);
      end else begin
        eq[i] = 1'b0;
      end
    end
    ordok[0] = eq[0];
    for (int j = 1; j < PENDING_DEPTH; j++) begin
      ordok[j] = ordok[j-1] & eq[j];
    end
    slot_ok = valid_r[ev_idx] & ent.usable;
    for (int j = 0; j < PENDING_DEPTH; j++) begin
      fm[j]      = st[j] == ent.mask;
      lane_ok[j] = (CNT_W'(j + 1) <= cnt_r) && slot_ok &&
                   ((st[j] & ~ent.mask) == '0) && (!ent.ordered || ordok[j]);
    end
  end

  // longest full-match prefix within the allowed length
  always_comb begin
    unique case (mode_r)
      M_FULLQ: trig_max = cnt_r;
      M_PRESS: trig_max = cnt_m1;
      M_FLUSH: trig_max = flush_c_r;
      default: trig_max = cnt_r;
    endcase
    tr_found = 1'b0;
    tr_len   = CNT_W'(1);
    for (int j = 0; j < PENDING_DEPTH; j++) begin
      if (fhit_r[j] && CNT_W'(j + 1) <= trig_max) begin
        tr_found = 1'b1;
        tr_len   = CNT_W'(j + 1);
      end
    end
    tr_t   = tr_len;
    tr_sel = PEND_W'(tr_len - 1'b1);
  end

  // first queued press of the released button
  always_comb begin
    rel_found = 1'b0;
    rel_c     = '0;
    for (int i = 0; i < PENDING_DEPTH; i++) begin
      if (!rel_found && CNT_W'(i) < cnt_r && key_r[i] == in_button) begin
        rel_found = 1'b1;
        rel_c     = CNT_W'(i + 1);
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    mode_nxt     = mode_r;
    kind_nxt     = kind_r;
    btn_nxt      = btn_r;
    now_nxt      = now_r;
    key_nxt      = key_r;
    time_nxt     = time_r;
    cnt_nxt      = cnt_r;
    active_nxt   = active_r;
    timer_nxt    = timer_r;
    deadline_nxt = deadline_r;
    valid_nxt    = valid_r;
    pressed_nxt  = pressed_r;
    released_nxt = released_r;
    rd_nxt       = rd_r;
    flush_c_nxt  = flush_c_r;
    fhit_nxt     = fhit_r;
    fidx_nxt     = fidx_r;
    phit_nxt     = phit_r;
    pwait_nxt    = pwait_r;
    hold_v_nxt     = hold_v_r;
    hold_ev_nxt    = hold_ev_r;
    hold_key_nxt   = hold_key_r;
    hold_combo_nxt = hold_combo_r;
    hold_stamp_nxt = hold_stamp_r;
    out_valid_nxt = 1'b0;
    out_last_nxt  = 1'b0;
    out_ev_nxt    = out_ev_r;
    out_key_nxt   = out_key_r;
    out_combo_nxt = out_combo_r;
    out_stamp_nxt = out_stamp_r;
    em_v     = 1'b0;
    em_ev    = EV_BTN_PRESS;
    em_key   = '0;
    em_combo = '0;
    em_stamp = '0;
    ram_we     = 1'b0;
    do_trig    = 1'b0;
    start_scan = 1'b0;
    pop_amt    = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          kind_nxt  = in_kind;
          btn_nxt   = in_button;
          now_nxt   = in_now_ms;
          state_nxt = S_DONE;
          unique case (in_kind)
            KIND_PRESS: begin
              if (btn_ok) begin
                if (!any_valid) begin
                  em_v = 1'b1; em_ev = EV_BTN_PRESS;
                  em_key = in_button; em_stamp = in_now_ms;
                end else if (int'(cnt_r) >= PENDING_DEPTH) begin
                  mode_nxt   = M_FULLQ;
                  start_scan = 1'b1;
                end else begin
                  key_nxt[cnt_r[PEND_W-1:0]]  = in_button;
                  time_nxt[cnt_r[PEND_W-1:0]] = in_now_ms;
                  cnt_nxt    = cnt_r + 1'b1;
                  mode_nxt   = M_PRESS;
                  start_scan = 1'b1;
                end
              end
            end
            KIND_RELEASE: begin
              if (btn_ok) begin
                if (!any_valid) begin
                  em_v = 1'b1; em_ev = EV_BTN_RELEASE;
                  em_key = in_button; em_stamp = in_now_ms;
                end else begin
                  timer_nxt = 1'b0;
                  if (rel_found) begin
                    flush_c_nxt = rel_c;
                    mode_nxt    = M_FLUSH;
                    start_scan  = 1'b1;
                  end else begin
                    state_nxt = S_REL_CHK;
                  end
                end
              end
            end
            KIND_TICK: begin
              if (timer_r && due) begin
                timer_nxt = 1'b0;
                if (cnt_r != '0) begin
                  flush_c_nxt = cnt_r;
                  mode_nxt    = M_FLUSH;
                  start_scan  = 1'b1;
                end
              end
            end
            KIND_DEFINE: begin
              if (slot_in_ok) begin
                ram_we = 1'b1;
                valid_nxt[ram_waddr]    = 1'b1;
                pressed_nxt[ram_waddr]  = 1'b0;
                released_nxt[ram_waddr] = 1'b1;
              end
            end
            KIND_RESET_ALL: begin
              rd_nxt    = '0;
              state_nxt = S_RSTALL;
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        rd_nxt = rd_r + 1'b1;
        if (rd_r != '0) begin
          // ascending walk: the highest matching slot ends up recorded
          for (int j = 0; j < PENDING_DEPTH; j++) begin
            if (lane_ok[j] && fm[j]) begin
              fhit_nxt[j] = 1'b1;
              fidx_nxt[j] = ev_idx;
            end
            if (lane_ok[j] && !fm[j] && CNT_W'(j + 1) == cnt_r) begin
              phit_nxt  = 1'b1;
              pwait_nxt = ent.wait_ms;
            end
          end
        end
        if (rd_r == SCAN_END) begin
          state_nxt = S_ACT;
        end
      end

      S_ACT: begin
        unique case (mode_r)
          M_FULLQ: begin
            do_trig   = 1'b1;
            state_nxt = S_PUSH;
          end
          M_PRESS: begin
            if (phit_r) begin
              if (pwait_r == '0) begin
                timer_nxt = 1'b0;
              end else begin
                timer_nxt    = 1'b1;
                deadline_nxt = now_r + TIME_W'(pwait_r);
              end
              state_nxt = S_DONE;
            end else if (fhit_r[cnt_sel]) begin
              pressed_nxt[fidx_r[cnt_sel]]  = 1'b1;
              released_nxt[fidx_r[cnt_sel]] = 1'b0;
              active_nxt = active_r | st[cnt_sel];
              em_v = 1'b1; em_ev = EV_COMBO_PRESS;
              em_combo = fidx_r[cnt_sel]; em_stamp = now_r;
              cnt_nxt   = '0;
              timer_nxt = 1'b0;
              state_nxt = S_DONE;
            end else begin
              do_trig = 1'b1;
              if (cnt_r != tr_t) begin
                start_scan = 1'b1;
              end else begin
                timer_nxt = 1'b0;
                state_nxt = S_DONE;
              end
            end
          end
          M_FLUSH: begin
            do_trig     = 1'b1;
            flush_c_nxt = flush_c_r - tr_t;
            if (flush_c_r != tr_t) begin
              start_scan = 1'b1;
            end else if (kind_r == KIND_RELEASE) begin
              state_nxt = S_REL_CHK;
            end else begin
              state_nxt = S_DONE;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end

      S_PUSH: begin
        key_nxt[cnt_r[PEND_W-1:0]]  = btn_r;
        time_nxt[cnt_r[PEND_W-1:0]] = now_r;
        cnt_nxt    = cnt_r + 1'b1;
        mode_nxt   = M_PRESS;
        start_scan = 1'b1;
      end

      S_REL_CHK: begin
        if (!active_r[btn_r]) begin
          em_v = 1'b1; em_ev = EV_BTN_RELEASE;
          em_key = btn_r; em_stamp = now_r;
          state_nxt = S_DONE;
        end else begin
          active_nxt[btn_r] = 1'b0;
          rd_nxt    = '0;
          state_nxt = S_RSCAN;
        end
      end

      S_RSCAN: begin
        rd_nxt = rd_r + 1'b1;
        if (rd_r != '0) begin
          if (valid_r[ev_idx] && pressed_r[ev_idx] && ent.mask[btn_r]) begin
            if (!released_r[ev_idx]) begin
              released_nxt[ev_idx] = 1'b1;
              em_v = 1'b1; em_ev = EV_COMBO_RELEASE;
              em_combo = ev_idx; em_stamp = now_r;
            end
            if ((active_r & ent.mask) == '0) begin
              pressed_nxt[ev_idx] = 1'b0;
            end
          end
        end
        if (rd_r == SCAN_END) begin
          state_nxt = S_DONE;
        end
      end

      S_RSTALL: begin
        rd_nxt = rd_r + 1'b1;
        if (valid_r[rd_r[SLOT_W-1:0]] && pressed_r[rd_r[SLOT_W-1:0]] &&
            !released_r[rd_r[SLOT_W-1:0]]) begin
          em_v = 1'b1; em_ev = EV_COMBO_RELEASE;
          em_combo = rd_r[SLOT_W-1:0]; em_stamp = now_r;
        end
        if (rd_r == SCAN_END - 1'b1) begin
          valid_nxt    = '0;
          pressed_nxt  = '0;
          released_nxt = '1;
          cnt_nxt      = '0;
          active_nxt   = '0;
          state_nxt    = S_DONE;
        end
      end

      S_DONE: state_nxt = S_IDLE;

      default: state_nxt = S_IDLE;
    endcase

    // resolve the queue head: longest full-match prefix, else a plain press
    if (do_trig) begin
      pop_amt = tr_t;
      if (tr_found) begin
        pressed_nxt[fidx_r[tr_sel]]  = 1'b1;
        released_nxt[fidx_r[tr_sel]] = 1'b0;
        active_nxt = active_r | st[tr_sel];
        em_v = 1'b1; em_ev = EV_COMBO_PRESS;
        em_combo = fidx_r[tr_sel]; em_stamp = time_r[tr_sel];
      end else begin
        em_v = 1'b1; em_ev = EV_BTN_PRESS;
        em_key = key_r[0]; em_stamp = time_r[0];
      end
    end

    if (pop_amt != '0) begin
      for (int i = 0; i < PENDING_DEPTH; i++) begin
        for (int k = 1; k < PENDING_DEPTH; k++) begin
          if (pop_amt == CNT_W'(k) && i + k < PENDING_DEPTH) begin
            key_nxt[i]  = key_r[i+k];
            time_nxt[i] = time_r[i+k];
          end
        end
      end
      cnt_nxt = cnt_r - pop_amt;
    end

    if (start_scan) begin
      fhit_nxt  = '0;
      phit_nxt  = 1'b0;
      rd_nxt    = '0;
      state_nxt = S_SCAN;
    end

    // one beat held back so the final beat of an event can carry last
    if (em_v) begin
      if (hold_v_r) begin
        out_valid_nxt = 1'b1;
        out_ev_nxt    = hold_ev_r;
        out_key_nxt   = hold_key_r;
        out_combo_nxt = hold_combo_r;
        out_stamp_nxt = hold_stamp_r;
      end
      hold_v_nxt     = 1'b1;
      hold_ev_nxt    = em_ev;
      hold_key_nxt   = em_key;
      hold_combo_nxt = em_combo;
      hold_stamp_nxt = em_stamp;
    end else if (state_r == S_DONE && hold_v_r) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = 1'b1;
      out_ev_nxt    = hold_ev_r;
      out_key_nxt   = hold_key_r;
      out_combo_nxt = hold_combo_r;
      out_stamp_nxt = hold_stamp_r;
      hold_v_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= M_PRESS;
      cnt_r       <= '0;
      active_r    <= '0;
      timer_r     <= 1'b0;
      deadline_r  <= '0;
      valid_r     <= '0;
      pressed_r   <= '0;
      released_r  <= '1;
      rd_r        <= '0;
      flush_c_r   <= '0;
      fhit_r      <= '0;
      phit_r      <= 1'b0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      cnt_r       <= cnt_nxt;
      active_r    <= active_nxt;
      timer_r     <= timer_nxt;
      deadline_r  <= deadline_nxt;
      valid_r     <= valid_nxt;
      pressed_r   <= pressed_nxt;
      released_r  <= released_nxt;
      rd_r        <= rd_nxt;
      flush_c_r   <= flush_c_nxt;
      fhit_r      <= fhit_nxt;
      phit_r      <= phit_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    btn_r        <= btn_nxt;
    now_r        <= now_nxt;
    key_r        <= key_nxt;
    time_r       <= time_nxt;
    fidx_r       <= fidx_nxt;
    pwait_r      <= pwait_nxt;
    hold_ev_r    <= hold_ev_nxt;
    hold_key_r   <= hold_key_nxt;
    hold_combo_r <= hold_combo_nxt;
    hold_stamp_r <= hold_stamp_nxt;
    out_ev_r     <= out_ev_nxt;
    out_key_r    <= out_key_nxt;
    out_combo_r  <= out_combo_nxt;
    out_stamp_r  <= out_stamp_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_last      = out_last_r;
  assign out_event_res = out_ev_r;
  assign out_key       = out_key_r;
  assign out_combo     = COMBO_W'(out_combo_r);
  assign out_stamp_ms  = out_stamp_r;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= PENDING_DEPTH)
    else $error("pending count past queue depth");

  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !hold_v_r)
    else $error("result left behind when going idle");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |=> !out_valid_r)
    else $error("beat right after final beat of an event");
`endif

endmodule

@@ sv/kcc_ram.sv @@
// ----------------------------------------------------------------------------
// kcc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module kcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
